[hdl/utf8sd_pkg.sv]
// Package with the constants and types of the UTF-8 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package utf8sd_pkg;

	// Widths of the payload fields.
	localparam int unsigned ByteW  = 8;
	localparam int unsigned CpW    = 21;
	localparam int unsigned CountW = 3;

	// Code point limits.
	localparam logic [CpW-1:0] ReplChar  = 21'h00FFFD;
	localparam logic [CpW-1:0] Min2Byte  = 21'h000080;
	localparam logic [CpW-1:0] Min3Byte  = 21'h000800;
	localparam logic [CpW-1:0] SurrLow   = 21'h00D800;
	localparam logic [CpW-1:0] SurrHigh  = 21'h00DFFF;
	localparam logic [CpW-1:0] Min4Byte  = 21'h010000;
	localparam logic [CpW-1:0] MaxCp     = 21'h10FFFF;

	// Length of the open sequence; none means no sequence is open.
	typedef enum logic [2:0] {
		SEQ_NONE = 3'd0,
		SEQ_TWO  = 3'd2,
		SEQ_THREE = 3'd3,
		SEQ_FOUR = 3'd4
	} seq_len_t;

endpackage

`default_nettype wire

[hdl/utf8_stream_decoder_unit.sv]
// UTF-8 stream decoder: turns a byte stream into code points.
// Each byte passes through the input register and then the result register, which
// offers its results. Throughput: one byte per cycle while each byte gives at most
// one result and out_ready stays high; a byte that gives n results (n is at most four)
// holds the result register until all n results are sent.
// Reset empties the input register and the result register and closes the open sequence.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_unit
	import utf8sd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [ByteW-1:0]  data_byte,
	input  wire logic              text_last,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [CpW-1:0]         code_point,
	output logic                   replaced,
	output logic                   run_last,
	output logic                   text_done
);

	// Input register.
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             last_s1;

	// Result register: count of results still to send and the final result.
	logic [CountW-1:0] cnt_s2;
	logic [CpW-1:0]    tail_cp_s2;
	logic              tail_rep_s2;
	logic              last_s2;

	// Decoder state.
	seq_len_t       seq_len_q;
	logic [1:0]     held_q;
	logic [CpW-1:0] partial_q;

	// Next-state and result values from the decode logic.
	seq_len_t          seq_len_d;
	logic [1:0]        held_d;
	logic [CpW-1:0]    partial_d;
	logic [CountW-1:0] cnt_d;
	logic [CpW-1:0]    tail_cp_d;
	logic              tail_rep_d;

	logic              load_s2;
	logic              out_xfer;

	// Helper terms for the decode.
	logic              seq_open;
	logic              is_cont;
	logic [CpW-1:0]    ext_value;
	logic [CountW-1:0] held_plus2;
	logic              complete;
	logic              bad_value;
	logic [CountW-1:0] flush_cnt;

	// Handshake.
	assign out_valid = (cnt_s2 != '0);
	assign out_xfer  = out_valid && out_ready;
	assign load_s2   = valid_s1 && ((cnt_s2 == '0) ||
		((cnt_s2 == CountW'(1)) && out_ready));
	assign in_ready  = !valid_s1 || load_s2;

	// Output fields: all results before the last are replacements.
	assign run_last   = (cnt_s2 == CountW'(1));
	assign code_point = run_last ? tail_cp_s2 : ReplChar;
	assign replaced   = run_last ? tail_rep_s2 : 1'b1;
	assign text_done  = run_last && last_s2;

	// Shared terms of the decode.
	assign seq_open   = (seq_len_q != SEQ_NONE);
	assign is_cont    = (byte_s1[7:6] == 2'b10);
	assign ext_value  = {partial_q[CpW-7:0], byte_s1[5:0]};
	assign held_plus2 = {1'b0, held_q} + CountW'(2);
	assign complete   = (held_plus2 >= CountW'(seq_len_q));
	assign flush_cnt  = seq_open ? ({1'b0, held_q} + CountW'(1)) : '0;

	// Range check of a completed sequence.
	always_comb begin
		case (seq_len_q)
			SEQ_TWO:   bad_value = (ext_value < Min2Byte);
			SEQ_THREE: bad_value = (ext_value < Min3Byte) ||
				((ext_value >= SurrLow) && (ext_value <= SurrHigh));
			default:   bad_value = (ext_value < Min4Byte) || (ext_value > MaxCp);
		endcase
	end

	// Decode of one byte against the open sequence.
	always_comb begin
		seq_len_d  = SEQ_NONE;
		held_d     = '0;
		partial_d  = '0;
		cnt_d      = '0;
		tail_cp_d  = ReplChar;
		tail_rep_d = 1'b1;
		if (seq_open && is_cont) begin
			if (complete) begin
				cnt_d      = CountW'(1);
				tail_cp_d  = bad_value ? ReplChar : ext_value;
				tail_rep_d = bad_value;
			end else if (last_s1) begin
				cnt_d = held_plus2;
			end else begin
				seq_len_d = seq_len_q;
				held_d    = held_q + 2'd1;
				partial_d = ext_value;
			end
		end else begin
			if (!byte_s1[7]) begin
				// Plain ASCII byte.
				cnt_d      = flush_cnt + CountW'(1);
				tail_cp_d  = {{(CpW-ByteW){1'b0}}, byte_s1};
				tail_rep_d = 1'b0;
			end else if (byte_s1[7:5] == 3'b110 || byte_s1[7:4] == 4'b1110 ||
				byte_s1[7:3] == 5'b11110) begin
				// Lead byte; a text end right here flushes it again.
				cnt_d = flush_cnt + (last_s1 ? CountW'(1) : CountW'(0));
				if (!last_s1) begin
					if (byte_s1[7:5] == 3'b110) begin
						seq_len_d = SEQ_TWO;
						partial_d = {{(CpW-5){1'b0}}, byte_s1[4:0]};
					end else if (byte_s1[7:4] == 4'b1110) begin
						seq_len_d = SEQ_THREE;
						partial_d = {{(CpW-4){1'b0}}, byte_s1[3:0]};
					end else begin
						seq_len_d = SEQ_FOUR;
						partial_d = {{(CpW-3){1'b0}}, byte_s1[2:0]};
					end
				end
			end else begin
				// Stray continuation or invalid byte.
				cnt_d = flush_cnt + CountW'(1);
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= text_last;
		end
	end

	// Result register count and decoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2    <= '0;
			seq_len_q <= SEQ_NONE;
			held_q    <= '0;
			partial_q <= '0;
		end else if (load_s2) begin
			cnt_s2    <= cnt_d;
			seq_len_q <= seq_len_d;
			held_q    <= held_d;
			partial_q <= partial_d;
		end else if (out_xfer) begin
			cnt_s2 <= cnt_s2 - CountW'(1);
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load_s2) begin
			tail_cp_s2  <= tail_cp_d;
			tail_rep_s2 <= tail_rep_d;
			last_s2     <= last_s1;
		end
	end

endmodule

`default_nettype wire
